// ===== sv/ksiu_pkg.sv =====
// Shared types, register offsets and key constants for the keyed software interrupt unit.
package ksiu_pkg;

   localparam int unsigned NUM_CHANNELS = 4;
   localparam int unsigned CHAN_W       = 2;

   // access kinds
   localparam logic FUNC_READ  = 1'b0;
   localparam logic FUNC_WRITE = 1'b1;

   // register offsets
   localparam logic [7:0] REQ_BASE  = 8'hB0;
   localparam logic [7:0] REQ_LAST  = 8'hBC;
   localparam logic [7:0] ESR_ADDR  = 8'hE0;
   localparam logic [7:0] VEC_ADDR  = 8'hF4;
   localparam logic [7:0] FLAG_ADDR = 8'hF8;

   localparam logic [31:0] KEY_MASK  = 32'h0000_FF00;
   localparam logic [31:0] DATA_MASK = 32'h0000_00FF;
   localparam logic [31:0] RST_SET   = 32'h0000_8000;
   localparam logic [31:0] RST_KEEP  = 32'h0000_4000;

   typedef struct packed {
      logic        func;
      logic [7:0]  addr;
      logic [31:0] wdata;
   } access_type;

   typedef struct packed {
      logic [31:0] rdata;
      logic        irq_level;
      logic        reset_request;
   } result_type;

   // key pattern (bits 15:8) for each request channel
   function automatic logic [31:0] chan_key(input logic [CHAN_W-1:0] ch);
      logic [31:0] key;
      case (ch)
         2'd0:    key = 32'h0000_7500;
         2'd1:    key = 32'h0000_8400;
         2'd2:    key = 32'h0000_9300;
         default: key = 32'h0000_A200;
      endcase
      return key;
   endfunction

endpackage

// ===== sv/keyed_software_interrupt_unit.sv =====
// Top level of the keyed software interrupt unit: input register, access logic, result register.
//
//   channel | ports                                        | direction
//   --------+----------------------------------------------+----------
//   request | req_valid req_ready req_func req_addr req_wdata | in
//   result  | rsp_valid rsp_ready rsp_rdata rsp_irq_level    | out
//           | rsp_reset_request                            |
//
// Each transaction lands in the input register, is processed in one pass
// through the access logic and is written to the result register, and one
// transaction per cycle sustains while rsp_ready keeps the result register
// draining.
// Register state (request bytes, pending flags) updates as the transaction
// moves into the result register, keeping state changes in bus order.
// Reset (synchronous) clears both stages, the request bytes and the flags.
// A stalled result holds the result register; the input register still takes
// a new transaction while it is empty, then stalls too.
module keyed_software_interrupt_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_func,
   input  logic [7:0]  req_addr,
   input  logic [31:0] req_wdata,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_rdata,
   output logic        rsp_irq_level,
   output logic        rsp_reset_request
);
   import ksiu_pkg::*;

   logic       s1_valid_ff, s1_valid_in;
   access_type s1_acc_ff,   s1_acc_in;
   logic       s2_valid_ff, s2_valid_in;
   result_type s2_res_ff,   s2_res_in;

   logic       advance;
   result_type core_res;

   // stage 1 moves forward when the result register is free or being drained
   assign advance   = s1_valid_ff && (!s2_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;

   ksiu_core u_core (
      .clock  (clock),
      .reset  (reset),
      .commit (advance),
      .acc    (s1_acc_ff),
      .res    (core_res)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_acc_in   = s1_acc_ff;
      if (req_valid && req_ready) begin
         s1_valid_in = 1'b1;
         s1_acc_in   = '{func: req_func, addr: req_addr, wdata: req_wdata};
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end

      s2_valid_in = s2_valid_ff;
      s2_res_in   = s2_res_ff;
      if (advance) begin
         s2_valid_in = 1'b1;
         s2_res_in   = core_res;
      end else if (rsp_ready) begin
         s2_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
      s1_acc_ff <= s1_acc_in;
      s2_res_ff <= s2_res_in;
   end

   assign rsp_valid         = s2_valid_ff;
   assign rsp_rdata         = s2_res_ff.rdata;
   assign rsp_irq_level     = s2_res_ff.irq_level;
   assign rsp_reset_request = s2_res_ff.reset_request;

   // reads never raise a reset request
   a_read_no_reset: assert property (@(posedge clock) disable iff (reset)
      (advance && s1_acc_ff.func == FUNC_READ) |=> !rsp_reset_request)
      else $error("reset request on a read transaction");

   // writes return zero read data
   a_write_zero_data: assert property (@(posedge clock) disable iff (reset)
      (advance && s1_acc_ff.func == FUNC_WRITE) |=> (rsp_rdata == '0))
      else $error("nonzero read data on a write transaction");

   // a blocked transaction in the input register is held, not dropped
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !advance) |=> (s1_valid_ff && $stable(s1_acc_ff)))
      else $error("stalled transaction lost from input register");

endmodule

// ===== sv/ksiu_core.sv =====
// Register state and single-pass access logic of the keyed software interrupt unit.
module ksiu_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  commit,
   input  ksiu_pkg::access_type  acc,
   output ksiu_pkg::result_type  res
);
   import ksiu_pkg::*;

   logic [7:0]              request_data_ff [NUM_CHANNELS];
   logic [7:0]              request_data_in [NUM_CHANNELS];
   logic [NUM_CHANNELS-1:0] pending_ff;
   logic [NUM_CHANNELS-1:0] pending_in;

   logic              is_req;
   logic [CHAN_W-1:0] ch;
   logic              key_ok;
   logic [2:0]        vec;
   logic [NUM_CHANNELS-1:0] vec_clr;

   assign is_req = (acc.addr >= REQ_BASE) && (acc.addr <= REQ_LAST);
   assign ch     = acc.addr[3:2];
   assign key_ok = ((acc.wdata & KEY_MASK) == chan_key(ch));

   // lowest pending channel, one-based
   always_comb begin
      vec     = 3'd0;
      vec_clr = '0;
      if (pending_ff[0]) begin
         vec = 3'd1; vec_clr = 4'b0001;
      end else if (pending_ff[1]) begin
         vec = 3'd2; vec_clr = 4'b0010;
      end else if (pending_ff[2]) begin
         vec = 3'd3; vec_clr = 4'b0100;
      end else if (pending_ff[3]) begin
         vec = 3'd4; vec_clr = 4'b1000;
      end
   end

   always_comb begin
      request_data_in   = request_data_ff;
      pending_in        = pending_ff;
      res.rdata         = '0;
      res.reset_request = 1'b0;
      if (acc.func == FUNC_WRITE) begin
         if (is_req) begin
            if (key_ok) begin
               request_data_in[ch] = acc.wdata[7:0];
               pending_in          = pending_ff | (NUM_CHANNELS'(1) << ch);
            end
         end else if (acc.addr == ESR_ADDR) begin
            res.reset_request = ((acc.wdata & RST_SET) != '0) ||
                                ((acc.wdata & RST_KEEP) == '0);
         end else if (acc.addr == FLAG_ADDR) begin
            pending_in = pending_ff & ~acc.wdata[NUM_CHANNELS-1:0];
         end
      end else begin
         if (is_req) begin
            res.rdata = {24'd0, request_data_ff[ch]};
         end else if (acc.addr == VEC_ADDR) begin
            res.rdata  = {29'd0, vec};
            pending_in = pending_ff & ~vec_clr;
         end else if (acc.addr == FLAG_ADDR) begin
            res.rdata = {28'd0, pending_ff};
         end
      end
      res.irq_level = (pending_in != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            request_data_ff[i] <= '0;
         end
      end else if (commit) begin
         pending_ff      <= pending_in;
         request_data_ff <= request_data_in;
      end
   end

endmodule
